// ===== src/xor_checked_sensor_frame_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame parser
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_SENSOR_FRAME_PARSER_CORE_MACROS_SVH
`define XOR_CHECKED_SENSOR_FRAME_PARSER_CORE_MACROS_SVH

// checked only while out of reset
`define XCSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define XCSFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/xcsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// xcsfp_pkg
// Types and constants of the XOR-checked sensor frame parser.
// ----------------------------------------------------------------------------
package xcsfp_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] LAST_POS     = 5'd21;
    localparam logic [7:0]       FRAME_LEN    = 8'd22;
    localparam logic [7:0]       HEADER_RESET = 8'd22;

    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_READ_FAIL = 3'd1,
        RC_BAD_HDR   = 3'd2,
        RC_BAD_LEN   = 3'd3,
        RC_BAD_CSUM  = 3'd4
    } t_result_code;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       bus_error;
    } t_in_item;

    typedef struct packed {
        t_result_code result_code;
        logic [7:0]   sensor_status;
        logic [15:0]  pm2p5_value;
        logic [15:0]  pm10_value;
        logic [15:0]  mode_word;
        logic [15:0]  calibration_coeff;
    } t_out_item;

endpackage

// ===== src/xcsfp_frame.sv =====
// ----------------------------------------------------------------------------
// xcsfp_frame
// Frame state: position count, running XOR, field capture and result forming.
// ----------------------------------------------------------------------------
module xcsfp_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  xcsfp_pkg::t_in_item  i_item,
    input  logic [7:0]           i_frame_header,
    output logic                 o_res_valid,
    output xcsfp_pkg::t_out_item o_res
);

    logic [xcsfp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                  r_xor, n_xor;
    logic                        r_hdr_bad, n_hdr_bad;
    logic                        r_len_bad, n_len_bad;
    logic [7:0]                  r_status, n_status;
    logic [3:0][15:0]            r_words, n_words;
    logic [7:0]                  r_high, n_high;

    logic [xcsfp_pkg::POS_W-1:0] pos;
    logic [1:0]                  word_sel;
    logic [7:0]                  b;

    assign b        = i_item.rx_byte;
    assign pos      = i_item.frame_start ? '0 : r_pos;
    assign word_sel = pos[2:1] - 2'd3;

    always_comb begin
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_hdr_bad   = r_hdr_bad;
        n_len_bad   = r_len_bad;
        n_status    = r_status;
        n_words     = r_words;
        n_high      = r_high;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (i_item.bus_error) begin
                n_pos             = '0;
                o_res_valid       = 1'b1;
                o_res.result_code = xcsfp_pkg::RC_READ_FAIL;
            end else if (pos != xcsfp_pkg::LAST_POS) begin
                n_xor = (pos == '0) ? b : (r_xor ^ b);
                priority if (pos == 5'd0) begin
                    n_hdr_bad = (b != i_frame_header);
                    n_len_bad = 1'b0;
                end else if (pos == 5'd1) begin
                    n_len_bad = (b != xcsfp_pkg::FRAME_LEN);
                end else if (pos == 5'd2) begin
                    n_status = b;
                end else if (pos >= 5'd5 && pos <= 5'd12) begin
                    if (pos[0]) begin
                        n_high = b;
                    end else begin
                        n_words[word_sel] = {r_high, b};
                    end
                end else begin
                    n_high = r_high;
                end
                n_pos = pos + 5'd1;
            end else begin
                o_res_valid = 1'b1;
                priority if (r_hdr_bad) begin
                    o_res.result_code = xcsfp_pkg::RC_BAD_HDR;
                end else if (r_len_bad) begin
                    o_res.result_code = xcsfp_pkg::RC_BAD_LEN;
                end else if (b != r_xor) begin
                    o_res.result_code = xcsfp_pkg::RC_BAD_CSUM;
                end else begin
                    o_res.result_code       = xcsfp_pkg::RC_OK;
                    o_res.sensor_status     = r_status;
                    o_res.pm2p5_value       = r_words[0];
                    o_res.pm10_value        = r_words[1];
                    o_res.mode_word         = r_words[2];
                    o_res.calibration_coeff = r_words[3];
                end
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_xor     <= '0;
            r_hdr_bad <= 1'b0;
            r_len_bad <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_xor     <= n_xor;
            r_hdr_bad <= n_hdr_bad;
            r_len_bad <= n_len_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_words  <= n_words;
        r_high   <= n_high;
    end

endmodule

// ===== src/xcsfp_out.sv =====
// ----------------------------------------------------------------------------
// xcsfp_out
// Result register with valid/stall handshake towards the consumer.
// ----------------------------------------------------------------------------
module xcsfp_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  xcsfp_pkg::t_out_item i_res,
    input  logic                 i_stall,
    output logic                 o_valid,
    output xcsfp_pkg::t_out_item o_item,
    output logic                 o_blocked
);

    logic                 r_valid, n_valid;
    xcsfp_pkg::t_out_item r_item, n_item;

    // held item not leaving this cycle
    assign o_blocked = r_valid & i_stall;
    assign n_valid   = i_res_valid | o_blocked;
    assign n_item    = i_res_valid ? i_res : r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/xor_checked_sensor_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// xor_checked_sensor_frame_parser_core
// Parses 22-byte XOR-checked particulate-sensor frames, one byte per item.
// ----------------------------------------------------------------------------
//  channel  signals                         direction
//  in       i_in_valid/o_in_stall/i_in_item  byte items in
//  out      o_out_valid/i_out_stall/o_out_item  result items out
//  cfg      i_cfg_valid/o_cfg_ready/i_cfg_data  frame header register write
//
//  One byte per cycle unless stalled; its result, if any, shows next cycle.
//  Frame state and result forming sit between the state registers and the
//  result register, so the rate is set by that single register stage.
//  Input stalls only while a result is held and the consumer stalls.
//  Synchronous reset: position 0, header register 22, no result held.
// ----------------------------------------------------------------------------
module xor_checked_sensor_frame_parser_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  xcsfp_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output xcsfp_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_cfg_ready
);

    logic [7:0]           r_hdr_val;
    logic                 in_accept;
    logic                 res_valid;
    xcsfp_pkg::t_out_item res;
    logic                 out_blocked;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = out_blocked;
    assign in_accept   = i_in_valid & ~out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_val <= xcsfp_pkg::HEADER_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_hdr_val <= i_cfg_data;
            end
        end
    end

    xcsfp_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_item         (i_in_item),
        .i_frame_header (r_hdr_val),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    xcsfp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item),
        .o_blocked   (out_blocked)
    );

endmodule

// ===== src/xcsfp_checker.sv =====
// ----------------------------------------------------------------------------
// xcsfp_checker
// Port-level assertions for the sensor frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "xor_checked_sensor_frame_parser_core_macros.svh"

module xcsfp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input xcsfp_pkg::t_in_item  i_in_item,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input xcsfp_pkg::t_out_item o_out_item,
    input logic                 i_out_stall
);

    `XCSFP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `XCSFP_ASSERT(a_out_hold,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item),
        "stalled result changed")

    `XCSFP_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall,
        "input stalled without a held result")

    `XCSFP_ASSERT(a_bus_error,
        i_in_valid && !o_in_stall && i_in_item.bus_error
            |=> o_out_valid && o_out_item.result_code == xcsfp_pkg::RC_READ_FAIL,
        "bus error gave no read failure")

    `XCSFP_ASSERT(a_err_zero,
        o_out_valid && o_out_item.result_code != xcsfp_pkg::RC_OK
            |-> o_out_item.sensor_status == 8'd0 && o_out_item.pm2p5_value == 16'd0
                && o_out_item.calibration_coeff == 16'd0,
        "failed result carries data")

endmodule

bind xor_checked_sensor_frame_parser_core xcsfp_checker u_xcsfp_checker (.*);

// ===== test/xor_checked_sensor_frame_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// xor_checked_sensor_frame_parser_core_tb
// Drives byte items of 22-byte sensor frames into the parser and checks
// every result item against a cycle-free model of the frame parsing. The
// run covers well-formed frames, each error class, bus errors, restarts and
// noise. It uses several frame header settings, random idling on both
// channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module xor_checked_sensor_frame_parser_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum {
        FK_GOOD,
        FK_BAD_HDR,
        FK_BAD_LEN,
        FK_BAD_CSUM,
        FK_BUS_ERR,
        FK_RESTART,
        FK_NOISE
    } t_frame_kind;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    xcsfp_pkg::t_in_item  in_item   = '0;
    logic                 in_stall;
    logic                 out_valid;
    xcsfp_pkg::t_out_item out_item;
    logic                 out_stall = 1'b1;
    logic                 cfg_valid = 1'b0;
    logic [7:0]           cfg_data  = '0;
    logic                 cfg_ready;

    // parser model state
    logic [7:0]  hdr_setting = xcsfp_pkg::HEADER_RESET;
    logic [4:0]  frame_pos   = '0;
    logic [7:0]  frame_xor   = '0;
    logic        hdr_bad     = 1'b0;
    logic        len_bad     = 1'b0;
    logic [7:0]  status_seen = '0;
    logic [15:0] words_seen [4] = '{default: '0};
    logic [7:0]  high_seen   = '0;

    xcsfp_pkg::t_out_item results_due [$];
    int        mismatches    = 0;
    int        bytes_sent    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    int        idle_cycles   = 0;
    bit        force_mark    = 1'b0;

    xor_checked_sensor_frame_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic clear_frame();
        frame_pos   = '0;
        frame_xor   = '0;
        hdr_bad     = 1'b0;
        len_bad     = 1'b0;
        status_seen = '0;
        words_seen  = '{default: '0};
        high_seen   = '0;
    endtask

    task automatic parse_frame_byte(input xcsfp_pkg::t_in_item it);
        xcsfp_pkg::t_out_item    res;
        logic [4:0]              pos;
        xcsfp_pkg::t_result_code code;
        res = '0;
        if (it.bus_error) begin
            clear_frame();
            res.result_code = xcsfp_pkg::RC_READ_FAIL;
            results_due.push_back(res);
            return;
        end
        if (it.frame_start)
            clear_frame();
        pos = (frame_pos > xcsfp_pkg::LAST_POS) ? '0 : frame_pos;
        if (pos < xcsfp_pkg::LAST_POS) begin
            frame_xor = (pos == 0) ? it.rx_byte : (frame_xor ^ it.rx_byte);
            if (pos == 0) begin
                hdr_bad = (it.rx_byte != hdr_setting);
                len_bad = 1'b0;
            end else if (pos == 1) begin
                len_bad = (it.rx_byte != xcsfp_pkg::FRAME_LEN);
            end else if (pos == 2) begin
                status_seen = it.rx_byte;
            end else if (pos >= 5 && pos <= 12) begin
                if (pos[0])
                    high_seen = it.rx_byte;
                else
                    words_seen[(int'(pos) - 6) >> 1] = {high_seen, it.rx_byte};
            end
            frame_pos = pos + 5'd1;
            return;
        end
        if (hdr_bad)
            code = xcsfp_pkg::RC_BAD_HDR;
        else if (len_bad)
            code = xcsfp_pkg::RC_BAD_LEN;
        else if (it.rx_byte != frame_xor)
            code = xcsfp_pkg::RC_BAD_CSUM;
        else
            code = xcsfp_pkg::RC_OK;
        res.result_code = code;
        if (code == xcsfp_pkg::RC_OK) begin
            res.sensor_status     = status_seen;
            res.pm2p5_value       = words_seen[0];
            res.pm10_value        = words_seen[1];
            res.mode_word         = words_seen[2];
            res.calibration_coeff = words_seen[3];
        end
        results_due.push_back(res);
        clear_frame();
    endtask

    // result side: random stall, or a long hold-off on request
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        xcsfp_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: code %0d", out_item.result_code);
            end else begin
                want = results_due.pop_front();
                if (out_item.result_code !== want.result_code
                        || out_item.sensor_status !== want.sensor_status
                        || out_item.pm2p5_value !== want.pm2p5_value
                        || out_item.pm10_value !== want.pm10_value
                        || out_item.mode_word !== want.mode_word
                        || out_item.calibration_coeff !== want.calibration_coeff) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch (exp/got): code %0d/%0d status %h/%h",
                                 want.result_code, out_item.result_code,
                                 want.sensor_status, out_item.sensor_status);
                        $display("  pm2.5 %h/%h pm10 %h/%h mode %h/%h coeff %h/%h",
                                 want.pm2p5_value, out_item.pm2p5_value,
                                 want.pm10_value, out_item.pm10_value,
                                 want.mode_word, out_item.mode_word,
                                 want.calibration_coeff, out_item.calibration_coeff);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
        xcsfp_pkg::t_in_item it;
        it = '{rx_byte: b, frame_start: s, bus_error: e};
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        parse_frame_byte(it);
        bytes_sent++;
    endtask

    task automatic write_header(input logic [7:0] value);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        hdr_setting  = value;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [7:0] f [22];
        logic [7:0] sum;
        int         cut;
        bit         mark;
        foreach (f[i])
            f[i] = 8'($urandom_range(255));
        f[0] = hdr_setting;
        f[1] = xcsfp_pkg::FRAME_LEN;
        if (kind == FK_BAD_HDR) begin
            f[0] = hdr_setting ^ 8'($urandom_range(1, 255));
            if ($urandom_range(1))
                f[1] = xcsfp_pkg::FRAME_LEN ^ 8'($urandom_range(1, 255));
        end
        if (kind == FK_BAD_LEN)
            f[1] = xcsfp_pkg::FRAME_LEN ^ 8'($urandom_range(1, 255));
        sum = '0;
        for (int i = 0; i < 21; i++)
            sum ^= f[i];
        f[21] = sum;
        if (kind == FK_BAD_CSUM || (kind != FK_GOOD && $urandom_range(1)))
            f[21] = sum ^ 8'($urandom_range(1, 255));
        mark       = force_mark || $urandom_range(1);
        force_mark = 1'b0;
        cut = 22;
        if (kind == FK_BUS_ERR)
            cut = $urandom_range(0, 21);
        else if (kind == FK_RESTART)
            cut = $urandom_range(1, 20);
        for (int i = 0; i < cut; i++)
            send_byte(f[i], (i == 0) && mark, 1'b0);
        if (kind == FK_BUS_ERR)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        if (kind == FK_RESTART)
            force_mark = 1'b1;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 20,
                      $urandom_range(99) < 10);
        force_mark = ($urandom_range(99) < 80);
    endtask

    task automatic random_traffic(input int count);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < count) begin
            pick = $urandom_range(99);
            if (pick < 50)      send_frame(FK_GOOD);
            else if (pick < 58) send_frame(FK_BAD_HDR);
            else if (pick < 66) send_frame(FK_BAD_LEN);
            else if (pick < 76) send_frame(FK_BAD_CSUM);
            else if (pick < 84) send_frame(FK_BUS_ERR);
            else if (pick < 92) send_frame(FK_RESTART);
            else                send_noise();
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // bus errors, unmarked byte 0, restart in mid-frame, a good frame at extremes
    task automatic test_directed_frames();
        logic [7:0] f [22] = '{8'd22, 8'd22, 8'hFF, 8'h00, 8'hFF,
                               8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01,
                               8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                               8'h01, 8'h02, 8'h04, 8'h08, 8'h00};
        for (int i = 0; i < 21; i++)
            f[21] ^= f[i];
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(xcsfp_pkg::HEADER_RESET, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        for (int i = 0; i < 22; i++)
            send_byte(f[i], i == 0, 1'b0);
    endtask

    task automatic test_header_extremes();
        write_header(8'h00);
        random_traffic(70);
        write_header(8'hFF);
        random_traffic(70);
        write_header(xcsfp_pkg::HEADER_RESET);
    endtask

    task automatic test_random_header();
        write_header(8'($urandom_range(255)));
        random_traffic(220);
    endtask

    task automatic test_result_hold_off();
        hold_requests++;
        random_traffic(60);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(19, 77);
        test_directed_frames();
        test_header_extremes();
        random_traffic(200);

        set_idling(77, 19);
        test_random_header();
        test_result_hold_off();

        set_idling(0, 0);
        write_header(xcsfp_pkg::HEADER_RESET);
        random_traffic(200);

        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== xor_checked_sensor_frame_parser_core.f =====
+incdir+src
src/xcsfp_pkg.sv
src/xcsfp_frame.sv
src/xcsfp_out.sv
src/xor_checked_sensor_frame_parser_core.sv
src/xcsfp_checker.sv
test/xor_checked_sensor_frame_parser_core_tb.sv
